// ===== hw/rtl/ept_pkg.sv =====
package ept_pkg;

	typedef struct packed {
		logic [39:0] id;
		logic [23:0] zero;
		logic [43:0] base;
		logic [19:0] size;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam logic [1:0] OP_DEREF  = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_REVOKE = 2'd2;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_RD_UNDER    = 4'd1;
	localparam logic [3:0] ST_RD_OVER     = 4'd2;
	localparam logic [3:0] ST_RD_FREED    = 4'd3;
	localparam logic [3:0] ST_WR_UNDER    = 4'd4;
	localparam logic [3:0] ST_WR_OVER     = 4'd5;
	localparam logic [3:0] ST_WR_FREED    = 4'd6;
	localparam logic [3:0] ST_PRIVATE     = 4'd7;
	localparam logic [3:0] ST_BAD_REVOKE  = 4'd8;
	localparam logic [3:0] ST_NONZERO_OFF = 4'd9;
	localparam logic [3:0] ST_ID_IN_USE   = 4'd10;
	localparam logic [3:0] ST_TABLE_FULL  = 4'd11;

	localparam logic [1:0] CFG_PROTECT_LOW  = 2'd0;
	localparam logic [1:0] CFG_PROTECT_HIGH = 2'd1;

	localparam logic [63:0] PROTECT_LOW_RST  = 64'h0000_0000_6FFF_F000;
	localparam logic [63:0] PROTECT_HIGH_RST = 64'h0000_0200_0000_0000;

	typedef struct packed {
		logic load;
		logic clear_step;
		logic probe;
		logic eval1;
		logic eval2;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic probe_done;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/ept_ram.sv =====
module ept_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hw/rtl/ept_ctrl.sv =====
module ept_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output ept_pkg::cmd_t cmd,
	input  ept_pkg::sts_t sts
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_PROBE = 3'd2;
	localparam logic [2:0] S_EVAL1 = 3'd3;
	localparam logic [2:0] S_EVAL2 = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PROBE;
				end
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.probe_done) begin
					state_d = S_EVAL1;
				end
			end
			S_EVAL1: begin
				cmd.eval1 = 1'b1;
				state_d   = S_EVAL2;
			end
			S_EVAL2: begin
				cmd.eval2 = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/ept_dp.sv =====
module ept_dp #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_PROBE   = 32,
	parameter int PAGE_BYTES  = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ept_pkg::cmd_t cmd,
	output ept_pkg::sts_t sts,
	input  logic [1:0]    operation,
	input  logic [63:0]   pointer,
	input  logic [31:0]   access_size,
	input  logic [31:0]   alignment,
	input  logic          is_write,
	input  logic [63:0]   random_key,
	input  logic          cfg_valid,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [63:0]   result_pointer,
	output logic [3:0]    status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(MAX_PROBE + 1);
	localparam logic [CW-1:0] PROBE_N = CW'(MAX_PROBE);
	localparam logic [23:0] PAGE_MASK = 24'(PAGE_BYTES - 1);
	localparam logic [31:0] PAGE_SIZE = 32'(PAGE_BYTES);

	logic [63:0] low_q, high_q;
	logic [1:0]  op_q;
	logic [63:0] ptr_q;
	logic [31:0] size_q;
	logic        wr_q, enc_q, bad_q, key_ok_q;
	logic [39:0] id_q;
	logic [23:0] mask_q, lsb_q, zero0_q, zero_q;

	logic [CW-1:0] issue_cnt_q, chk_cnt_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          hit_q, free_q;
	logic [AW-1:0] slot_q, free_slot_q;
	ept_pkg::entry_t entry_q;

	logic [AW-1:0] clr_cnt_q;

	logic        lt_q, ge_q, below_high_q;
	logic [63:0] diff_q;

	logic [63:0] res_q;
	logic [3:0]  st_q;
	logic        out_valid_q;

	logic [23:0] mask_d;
	logic [23:0] lsb_d;
	logic [39:0] id_d;
	logic        need_probe;
	logic        issue;
	logic [AW-1:0] probe_addr;
	logic [AW-1:0] ram_addr;
	logic        ram_we;
	ept_pkg::entry_t ram_wdata;
	logic [ept_pkg::ENTRY_W-1:0] ram_rdata;
	ept_pkg::entry_t rd_entry;
	logic [63:0] lb;
	logic [64:0] raw_sum;
	logic [32:0] zsum;
	logic [23:0] zfix;
	logic        ovf;
	logic [63:0] xlate;
	logic [63:0] res_d;
	logic [3:0]  st_d;
	logic        do_wr;
	ept_pkg::entry_t wr_entry;
	logic [AW-1:0] wr_slot;
	logic [3:0]  wofs;

	assign mask_d = (alignment > PAGE_SIZE) ? (alignment[23:0] - 24'd1) : PAGE_MASK;
	assign lsb_d  = pointer[23:0] & mask_d;
	assign id_d   = (operation == ept_pkg::OP_ENCODE) ? random_key[63:24] : pointer[63:24];

	assign need_probe = ((op_q == ept_pkg::OP_DEREF) && enc_q)
		|| ((op_q == ept_pkg::OP_REVOKE) && enc_q)
		|| ((op_q == ept_pkg::OP_ENCODE) && !bad_q && key_ok_q);

	assign issue      = cmd.probe && (issue_cnt_q != PROBE_N);
	assign probe_addr = id_q[AW-1:0] + AW'(issue_cnt_q);
	assign rd_entry   = ram_rdata;

	assign sts.clear_last = (&clr_cnt_q);
	assign sts.probe_done = !need_probe || hit_q || (chk_cnt_q == PROBE_N);
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= ept_pkg::PROTECT_LOW_RST;
			high_q <= ept_pkg::PROTECT_HIGH_RST;
		end else if (cfg_valid) begin
			if (cfg_index == ept_pkg::CFG_PROTECT_LOW) begin
				low_q <= cfg_data;
			end
			if (cfg_index == ept_pkg::CFG_PROTECT_HIGH) begin
				high_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= operation;
			ptr_q    <= pointer;
			size_q   <= access_size;
			wr_q     <= is_write;
			id_q     <= id_d;
			enc_q    <= |pointer[63:48];
			key_ok_q <= |random_key[63:48];
			bad_q    <= (|pointer[63:48]) || (pointer == 64'd0)
				|| (access_size > 32'hFFFFF) || (alignment > 32'hFFFFF)
				|| ((alignment & (alignment - 32'd1)) != 32'd0)
				|| (pointer[3:0] != 4'd0);
			mask_q   <= mask_d;
			lsb_q    <= lsb_d;
			zero0_q  <= (random_key[23:0] & ~mask_d) | lsb_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_cnt_q <= '0;
			chk_cnt_q   <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.load) begin
				issue_cnt_q <= '0;
				chk_cnt_q   <= '0;
				rd_vld_s1   <= 1'b0;
				hit_q       <= 1'b0;
				free_q      <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					issue_cnt_q <= issue_cnt_q + CW'(1);
				end
				if (cmd.probe && rd_vld_s1 && !hit_q) begin
					chk_cnt_q <= chk_cnt_q + CW'(1);
					if (rd_entry.id == id_q) begin
						hit_q <= 1'b1;
					end else if ((rd_entry.id == 40'd0) && !free_q) begin
						free_q <= 1'b1;
					end
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= probe_addr;
		if (cmd.probe && rd_vld_s1 && !hit_q) begin
			if (rd_entry.id == id_q) begin
				slot_q  <= rd_addr_s1;
				entry_q <= rd_entry;
			end else if ((rd_entry.id == 40'd0) && !free_q) begin
				free_slot_q <= rd_addr_s1;
			end
		end
	end

	assign lb      = {entry_q.id, entry_q.zero};
	assign raw_sum = {1'b0, ptr_q} + 65'(size_q);
	assign zsum    = {9'd0, zero0_q} + {1'b0, size_q};
	assign zfix    = (((zero0_q & ~mask_q) - size_q[23:0]) & ~mask_q) | lsb_q;

	always_ff @(posedge clk) begin
		if (cmd.eval1) begin
			lt_q         <= ptr_q < lb;
			diff_q       <= ptr_q - lb;
			ge_q         <= raw_sum >= {1'b0, low_q};
			below_high_q <= ptr_q < high_q;
			zero_q       <= (|zsum[32:24]) ? zfix : zero0_q;
		end
	end

	assign ovf   = ({1'b0, diff_q} + 65'(size_q)) > 65'(entry_q.size);
	assign xlate = 64'({entry_q.base, 4'd0}) + diff_q;
	assign wofs  = wr_q ? 4'd3 : 4'd0;

	always_comb begin
		res_d    = ptr_q;
		st_d     = ept_pkg::ST_OK;
		do_wr    = 1'b0;
		wr_entry = entry_q;
		wr_slot  = slot_q;
		case (op_q)
			ept_pkg::OP_DEREF: begin
				if (!enc_q) begin
					st_d = (ge_q && below_high_q) ? ept_pkg::ST_PRIVATE : ept_pkg::ST_OK;
				end else if (!hit_q) begin
					st_d = ept_pkg::ST_RD_FREED + wofs;
				end else if (lt_q) begin
					st_d = ept_pkg::ST_RD_UNDER + wofs;
				end else if (ovf) begin
					st_d = ept_pkg::ST_RD_OVER + wofs;
				end else begin
					res_d = xlate;
				end
			end
			ept_pkg::OP_ENCODE: begin
				if (bad_q) begin
					st_d = ept_pkg::ST_OK;
				end else if (!key_ok_q || hit_q) begin
					st_d = ept_pkg::ST_ID_IN_USE;
				end else if (!free_q) begin
					st_d = ept_pkg::ST_TABLE_FULL;
				end else begin
					res_d         = {id_q, zero_q};
					do_wr         = 1'b1;
					wr_slot       = free_slot_q;
					wr_entry.id   = id_q;
					wr_entry.zero = zero_q;
					wr_entry.base = ptr_q[47:4];
					wr_entry.size = size_q[19:0];
				end
			end
			ept_pkg::OP_REVOKE: begin
				if (!enc_q) begin
					st_d = ept_pkg::ST_OK;
				end else if (!hit_q) begin
					st_d = ept_pkg::ST_BAD_REVOKE;
				end else begin
					res_d       = {16'd0, entry_q.base, 4'd0};
					st_d        = (ptr_q[23:0] != entry_q.zero) ?
						ept_pkg::ST_NONZERO_OFF : ept_pkg::ST_OK;
					do_wr       = 1'b1;
					wr_entry.id = 40'd0;
				end
			end
			default: begin
				st_d = ept_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.eval2) begin
			res_q <= res_d;
			st_q  <= st_d;
		end
		if (cmd.out_load) begin
			result_pointer <= res_q;
			status         <= st_q;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = probe_addr;
		ram_wdata = wr_entry;
		if (cmd.clear_step) begin
			ram_we    = 1'b1;
			ram_addr  = clr_cnt_q;
			ram_wdata = '0;
		end else if (cmd.eval2 && do_wr) begin
			ram_we   = 1'b1;
			ram_addr = wr_slot;
		end
	end

	ept_ram #(
		.WIDTH (ept_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/encoded_pointer_bounds_translator_unit.sv =====
// A word is accepted in IDLE, probes up to MAX_PROBE table slots in PROBE, is evaluated in
// EVAL1 and EVAL2, and waits in DONE until the output register is free to take it.
// Throughput: one word at a time; the single table port sets the probe loop rate.
// Reset: asynchronous, active low; the table is then cleared entry by entry
// with in_ready low; configuration writes are taken at any time.
module encoded_pointer_bounds_translator_unit #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_PROBE   = 32,
	parameter int PAGE_BYTES  = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] pointer,
	input  logic [31:0] access_size,
	input  logic [31:0] alignment,
	input  logic        is_write,
	input  logic [63:0] random_key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_pointer,
	output logic [3:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	ept_pkg::cmd_t cmd;
	ept_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ept_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ept_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_PROBE   (MAX_PROBE),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.pointer        (pointer),
		.access_size    (access_size),
		.alignment      (alignment),
		.is_write       (is_write),
		.random_key     (random_key),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_pointer (result_pointer),
		.status         (status)
	);

endmodule

// ===== hw/rtl/ept_chk.sv =====
module ept_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_pointer,
	input logic [3:0]  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_pointer) && $stable(status))
		else $error("result word changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ept_pkg::ST_TABLE_FULL)
		else $error("status code out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a word while busy");

	a_bounds_encoded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ept_pkg::ST_RD_UNDER || status == ept_pkg::ST_RD_OVER
			|| status == ept_pkg::ST_RD_FREED || status == ept_pkg::ST_WR_UNDER
			|| status == ept_pkg::ST_WR_OVER || status == ept_pkg::ST_WR_FREED)
		|-> result_pointer[63:48] != 16'd0)
		else $error("bounds error on an unencoded pointer");

endmodule

bind encoded_pointer_bounds_translator_unit ept_chk u_ept_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.result_pointer (result_pointer),
	.status         (status)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ept_pkg::*;

	localparam int DEPTH     = 4096;
	localparam int PROBE     = 32;
	localparam int PAGE      = 4096;
	localparam int IDLE_MAX  = 20000;
	localparam int N_RANDOM  = 1300;

	typedef struct {
		logic [63:0] ptr;
		logic [3:0]  st;
	} answer_t;

	class translation_board;
		answer_t pending[$];
		int mismatches;
		int checked;

		function void note(answer_t a);
			pending.push_back(a);
		endfunction

		function void check(logic [63:0] ptr, logic [3:0] st);
			answer_t a;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: ptr=%h status=%0d", ptr, st);
				return;
			end
			a = pending.pop_front();
			if (ptr !== a.ptr || st !== a.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch #%0d: ptr exp %h got %h, status exp %0d got %0d",
						checked, a.ptr, ptr, a.st, st);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [63:0] pointer;
	logic [31:0] access_size;
	logic [31:0] alignment;
	logic        is_write;
	logic [63:0] random_key;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_pointer;
	logic [3:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	encoded_pointer_bounds_translator_unit DUT (.*);

	translation_board board;

	bit [39:0] obj_id   [DEPTH];
	bit [23:0] obj_zero [DEPTH];
	bit [43:0] obj_base [DEPTH];
	bit [19:0] obj_size [DEPTH];
	logic [63:0] prot_lo;
	logic [63:0] prot_hi;

	logic [63:0] live_ptr[$];
	int          live_size[$];
	logic [63:0] dead_ptr[$];
	logic [63:0] used_key[$];

	bit long_hold_req;
	bit send_burst;
	int idle_cycles;
	int sent;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int lookup_slot(logic [39:0] id);
		int s;
		for (int i = 0; i < PROBE; i++) begin
			s = (id + i) & (DEPTH - 1);
			if (obj_id[s] == id)
				return s;
		end
		return -1;
	endfunction

	function automatic answer_t translate(logic [1:0] op, logic [63:0] p, logic [31:0] sz,
			logic [31:0] al, logic wr, logic [63:0] key);
		answer_t a;
		logic [64:0] sum;
		logic [63:0] lb, diff, mask, zero, sz64, al64, lsb;
		logic [39:0] id;
		logic [3:0] w;
		int s;
		bit enc;
		a.ptr = p;
		a.st = ST_OK;
		enc = p[63:48] != 0;
		sz64 = {32'h0, sz};
		al64 = {32'h0, al};
		w = wr ? 4'd3 : 4'd0;
		case (op)
			OP_DEREF: begin
				if (!enc) begin
					sum = {1'b0, p} + {1'b0, sz64};
					if ((sum[64] || sum[63:0] >= prot_lo) && p < prot_hi)
						a.st = ST_PRIVATE;
				end else begin
					s = lookup_slot(p[63:24]);
					if (s < 0)
						a.st = ST_RD_FREED + w;
					else begin
						lb = {obj_id[s], obj_zero[s]};
						diff = p - lb;
						if (p < lb)
							a.st = ST_RD_UNDER + w;
						else if (diff + sz64 > {44'h0, obj_size[s]})
							a.st = ST_RD_OVER + w;
						else
							a.ptr = {obj_base[s], 4'h0} + diff;
					end
				end
			end
			OP_ENCODE: begin
				if (enc || p == 0 || sz > 32'hFFFFF || al > 32'hFFFFF ||
						((al64 - 1) & al64) != 0 || p[3:0] != 0)
					return a;
				if (key[63:48] == 0) begin
					a.st = ST_ID_IN_USE;
					return a;
				end
				id = key[63:24];
				if (lookup_slot(id) >= 0) begin
					a.st = ST_ID_IN_USE;
					return a;
				end
				s = -1;
				for (int i = 0; i < PROBE; i++)
					if (s < 0 && obj_id[(id + i) & (DEPTH - 1)] == 0)
						s = (id + i) & (DEPTH - 1);
				if (s < 0) begin
					a.st = ST_TABLE_FULL;
					return a;
				end
				mask = PAGE - 1;
				if (al64 > mask + 1)
					mask = al64 - 1;
				lsb = p & mask;
				zero = ({40'h0, key[23:0]} & ~mask) | lsb;
				if (((zero + sz64) & ~64'hFFFFFF) != 0)
					zero = ((((zero & ~mask) - sz64) & ~mask) | lsb);
				obj_id[s] = id;
				obj_zero[s] = zero[23:0];
				obj_size[s] = sz[19:0];
				obj_base[s] = p[47:4];
				a.ptr = {id, zero[23:0]};
			end
			OP_REVOKE: begin
				if (enc) begin
					s = lookup_slot(p[63:24]);
					if (s < 0)
						a.st = ST_BAD_REVOKE;
					else begin
						obj_id[s] = 0;
						a.ptr = {obj_base[s], 4'h0};
						a.st = (p[23:0] != obj_zero[s]) ? ST_NONZERO_OFF : ST_OK;
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic send_word(logic [1:0] op, logic [63:0] p, logic [31:0] sz,
			logic [31:0] al, logic wr, logic [63:0] key, output answer_t a);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pointer <= p;
		access_size <= sz;
		alignment <= al;
		is_write <= wr;
		random_key <= key;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		a = translate(op, p, sz, al, wr, key);
		board.note(a);
		sent++;
		if ($urandom_range(0, 31) == 0)
			send_burst = !send_burst;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_PROTECT_LOW)
			prot_lo = val;
		else
			prot_hi = val;
	endtask

	function automatic logic [63:0] pick_key();
		logic [11:0] home;
		logic [39:0] id;
		case ($urandom_range(0, 2))
			0: home = 12'd7;
			1: home = 12'd4090;
			default: home = 12'($urandom);
		endcase
		id = {16'($urandom_range(1, 65535)), 10'h0, 2'($urandom), home};
		return {id, 24'($urandom)};
	endfunction

	function automatic logic [63:0] pick_raw();
		logic [63:0] p;
		p = {16'h0, 32'($urandom), 16'($urandom)} & ~64'hF;
		if ($urandom_range(0, 3) == 0)
			p = {52'h0, 8'($urandom), 4'h0};
		return (p == 0) ? 64'h10 : p;
	endfunction

	function automatic logic [31:0] pick_align();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom;
			2: return 32'($urandom_range(3, 100));
			default: return 32'h1 << $urandom_range(0, 19);
		endcase
	endfunction

	task automatic do_encode(logic [63:0] p, logic [31:0] sz, logic [31:0] al,
			logic [63:0] key);
		answer_t a;
		send_word(OP_ENCODE, p, sz, al, $urandom_range(0, 1), key, a);
		if (a.st == ST_OK && p[63:48] == 16'h0 && a.ptr[63:48] != 16'h0) begin
			live_ptr.push_back(a.ptr);
			live_size.push_back(sz);
			used_key.push_back(key);
		end
	endtask

	task automatic do_revoke(int k, logic [63:0] off);
		answer_t a;
		logic [63:0] p;
		p = live_ptr[k];
		send_word(OP_REVOKE, p + off, $urandom, $urandom, $urandom_range(0, 1), $urandom, a);
		if (a.st == ST_OK || a.st == ST_NONZERO_OFF) begin
			dead_ptr.push_back(p);
			live_ptr.delete(k);
			live_size.delete(k);
		end
	endtask

	task automatic random_word();
		answer_t a;
		int k, r, sz;
		logic [63:0] off, p;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			if ($urandom_range(0, 9) == 0 && used_key.size() > 0)
				do_encode(pick_raw(), $urandom_range(0, 4096), 0,
					used_key[$urandom_range(0, used_key.size() - 1)]);
			else if ($urandom_range(0, 19) == 0)
				do_encode(pick_raw() | $urandom_range(0, 1), $urandom, pick_align(),
					{16'($urandom_range(0, 1)), 48'($urandom)});
			else
				do_encode(pick_raw(), ($urandom_range(0, 7) == 0) ?
					$urandom_range(0, 20'hFFFFF) : $urandom_range(0, 4096),
					pick_align(), pick_key());
		end else if (r < 75 && live_ptr.size() > 0) begin
			k = $urandom_range(0, live_ptr.size() - 1);
			sz = live_size[k];
			off = 64'($signed($urandom_range(0, sz + 32)) - 16);
			send_word(OP_DEREF, live_ptr[k] + off, ($urandom_range(0, 9) == 0) ?
				$urandom : $urandom_range(0, 16), $urandom, $urandom_range(0, 1),
				$urandom, a);
		end else if (r < 90 && live_ptr.size() > 0) begin
			k = $urandom_range(0, live_ptr.size() - 1);
			do_revoke(k, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : 0);
		end else if (r < 94 && dead_ptr.size() > 0) begin
			p = dead_ptr[$urandom_range(0, dead_ptr.size() - 1)];
			send_word($urandom_range(0, 1) ? OP_DEREF : OP_REVOKE, p, $urandom_range(0, 8),
				0, $urandom_range(0, 1), $urandom, a);
		end else begin
			p = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} :
				prot_lo + 64'($signed($urandom_range(0, 64)) - 32);
			send_word(2'($urandom), p, $urandom, $urandom, $urandom_range(0, 1),
				{$urandom, $urandom}, a);
		end
	endtask

	initial begin
		int stall;
		bit burst;
		out_ready = 1'b0;
		stall = 0;
		burst = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check(result_pointer, status);
				if ($urandom_range(0, 31) == 0)
					burst = !burst;
				stall = burst ? 0 : $urandom_range(0, 8);
				if (long_hold_req) begin
					long_hold_req = 0;
					stall = 400;
				end
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("[encoded_pointer_bounds_translator_unit] ERROR");
			$finish;
		end
	end

	initial begin
		answer_t a;
		logic [63:0] k1, k2;
		board = new();
		sent = 0;
		send_burst = 0;
		long_hold_req = 0;
		prot_lo = PROTECT_LOW_RST;
		prot_hi = PROTECT_HIGH_RST;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_DEREF;
		pointer = '0;
		access_size = '0;
		alignment = '0;
		is_write = 1'b0;
		random_key = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PROTECT_LOW;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		k1 = {40'hABCD_0000_07, 24'hFFFF00};
		k2 = {40'h0001_0000_07, 24'h123456};
		do_encode(64'h0, 16, 0, k1);
		do_encode(64'h1008, 16, 0, k1);
		do_encode(64'h1000, 32'h100000, 0, k1);
		do_encode(64'h1000, 16, 3, k1);
		do_encode(64'h1000, 16, 32'h100000, k1);
		do_encode(64'h1000, 16, 0, {16'h0, 48'h123456789ABC});
		do_encode(64'hFFFF_0000_0000_1000, 16, 0, k1);
		do_encode(64'h0000_FFFF_FFFF_F230, 20'hFFFFF, 0, k1);
		do_encode(64'h2000, 64, 0, k1);
		do_encode(64'h4000, 256, 32'h2000, k2);
		send_word(OP_DEREF, live_ptr[0], 16, 0, 0, 0, a);
		send_word(OP_DEREF, live_ptr[1] + 255, 1, 0, 1, 0, a);
		send_word(OP_DEREF, live_ptr[1] - 1, 1, 0, 0, 0, a);
		send_word(OP_DEREF, live_ptr[1] - 1, 1, 0, 1, 0, a);
		send_word(OP_DEREF, live_ptr[1] + 250, 7, 0, 0, 0, a);
		send_word(OP_DEREF, live_ptr[1] + 250, 32'hFFFFFFFF, 0, 1, 0, a);
		send_word(OP_DEREF, 64'h6FFF_EFFF, 1, 0, 0, 0, a);
		send_word(OP_DEREF, 64'hFFFF_FFFF_FFFF, 32'hFFFFFFFF, 0, 0, 0, a);
		send_word(OP_REVOKE, 64'h1234, 0, 0, 0, 0, a);
		send_word(OP_REVOKE, 64'h7777_0000_0000_0000, 0, 0, 0, 0, a);
		send_word(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
			64'hFFFF_FFFF_FFFF_FFFF, a);
		do_revoke(1, 8);
		do_revoke(0, 0);
		send_word(OP_DEREF, dead_ptr[0], 1, 0, 0, 0, a);
		send_word(OP_DEREF, dead_ptr[1], 1, 0, 1, 0, a);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 4) begin
				drain();
				write_reg(CFG_PROTECT_LOW, 64'h0);
				write_reg(CFG_PROTECT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
			end else if (i == N_RANDOM / 2) begin
				drain();
				write_reg(CFG_PROTECT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
				write_reg(CFG_PROTECT_HIGH, 64'h0);
				long_hold_req = 1;
			end else if (i == 3 * N_RANDOM / 4) begin
				drain();
				write_reg(CFG_PROTECT_LOW, {16'h0, $urandom, 16'($urandom)});
				write_reg(CFG_PROTECT_HIGH, {16'h0, $urandom | 32'h8000_0000, 16'h0});
			end
			random_word();
		end
		drain();

		if (board.pending.size() != 0) begin
			board.mismatches += board.pending.size();
			$display("%0d results never arrived", board.pending.size());
		end
		$display("sent %0d words, checked %0d results, %0d objects still live",
			sent, board.checked, live_ptr.size());
		$display("covered encode/deref/revoke incl. wrap, full probe windows and 4 region settings");
		if (board.mismatches == 0)
			$display("[encoded_pointer_bounds_translator_unit] OK");
		else
			$display("[encoded_pointer_bounds_translator_unit] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/ept_pkg.sv
hw/rtl/ept_ram.sv
hw/rtl/ept_ctrl.sv
hw/rtl/ept_dp.sv
hw/rtl/encoded_pointer_bounds_translator_unit.sv
hw/rtl/ept_chk.sv
bench/tb.sv
